>>> rtl/hct_pkg.sv
// Shared types and constants for the canonical Huffman code table.
// Used by the channel interfaces, the controller, the datapath and the top level.
package hct_pkg;

   localparam int ACTION_W        = 2;
   localparam int SYMBOL_W        = 9;
   localparam int LENGTH_W        = 4;
   localparam int CODE_W          = 15;
   localparam int WINDOW_W        = 15;
   localparam int COUNT_W         = 9;
   localparam int HIST_W          = 9;
   localparam int NEXT_W          = 16;
   localparam int MAX_CODE_BITS   = 15;
   localparam int LEN_BINS        = MAX_CODE_BITS + 1;
   localparam int MAX_SYMBOLS_DEF = 288;
   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(288);

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD   = 2'd0,
      ACT_BUILD  = 2'd1,
      ACT_LOOKUP = 2'd2,
      ACT_DECODE = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_LOOKUP_RD,
      ST_LOOKUP_RES,
      ST_CLEAR,
      ST_COUNT,
      ST_NEXT,
      ST_ASSIGN,
      ST_DECODE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic accept;
      logic load_wr;
      logic lookup_rd;
      logic lookup_res;
      logic build_clear;
      logic scan_start;
      logic scan_stop;
      logic count_en;
      logic next_step;
      logic assign_en;
      logic decode_en;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic bits_last;
      logic match;
      logic rsp_free;
   } status_type;

endpackage

>>> rtl/hct_req_if.sv
// Request channel of the code table: valid/ready plus one request item.
// Depends on hct_pkg for field widths.
interface hct_req_if;
   logic                           valid;
   logic                           ready;
   logic [hct_pkg::ACTION_W-1:0]   action;
   logic [hct_pkg::SYMBOL_W-1:0]   symbol;
   logic [hct_pkg::LENGTH_W-1:0]   length;
   logic [hct_pkg::WINDOW_W-1:0]   bit_window;

   modport source (output valid, action, symbol, length, bit_window, input ready);
   modport sink   (input valid, action, symbol, length, bit_window, output ready);
endinterface

>>> rtl/hct_rsp_if.sv
// Response channel of the code table: valid/ready plus one result item.
// Depends on hct_pkg for field widths.
interface hct_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           found;
   logic [hct_pkg::SYMBOL_W-1:0]   result_symbol;
   logic [hct_pkg::CODE_W-1:0]     code;
   logic [hct_pkg::LENGTH_W-1:0]   code_length;

   modport source (output valid, found, result_symbol, code, code_length, input ready);
   modport sink   (input valid, found, result_symbol, code, code_length, output ready);
endinterface

>>> rtl/canonical_huffman_code_table.sv
// Canonical Huffman code table, DEFLATE style. Load writes one symbol's code length,
// build assigns canonical codes to the first symbol_count symbols, lookup returns a
// symbol's code and length, decode returns the lowest symbol whose code matches the
// head of a 15-bit window. One item is worked on at a time; a finished item waits in
// the response register while the next is accepted. A build walks the active symbols
// twice, to count lengths and then to assign codes, with 15 first-code steps between
// the walks; a decode walk stops at the first match. The build and decode walks
// read the length and code tables through one RAM read port, one symbol per cycle. The
// tables are not cleared at reset: load every symbol that a build or decode will walk,
// and build before lookup or decode.
module canonical_huffman_code_table #(
   parameter int MAX_SYMBOLS = hct_pkg::MAX_SYMBOLS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   hct_req_if.sink                       req_if,
   hct_rsp_if.source                     rsp_if,
   input  logic                          csr_we,
   input  logic [hct_pkg::COUNT_W-1:0]   csr_wdata
);

   hct_pkg::cmd_type    cmd;
   hct_pkg::status_type status;
   logic                req_ready;

   hct_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_action (hct_pkg::action_type'(req_if.action)),
      .status     (status),
      .cmd        (cmd),
      .req_ready  (req_ready)
   );

   hct_dp #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_symbol        (req_if.symbol),
      .req_length        (req_if.length),
      .req_bit_window    (req_if.bit_window),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .rsp_ready         (rsp_if.ready),
      .rsp_valid         (rsp_if.valid),
      .rsp_found         (rsp_if.found),
      .rsp_result_symbol (rsp_if.result_symbol),
      .rsp_code          (rsp_if.code),
      .rsp_code_length   (rsp_if.code_length)
   );

   assign req_if.ready = req_ready;

   // one item at a time: after an accept the request side closes
   assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("request accepted while an item is in progress");

   // a hit always carries a nonzero length
   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.found) |-> (rsp_if.code_length != '0))
      else $error("found result with zero code length");

   // a miss, load or build result carries no code and no length
   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.found) |-> (rsp_if.code == '0 && rsp_if.code_length == '0))
      else $error("result without a hit carries a code");

   // the response register is only loaded while the request side is closed
   assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_load) |-> !req_if.ready)
      else $error("response loaded while idle");

endmodule

>>> rtl/hct_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> rtl/hct_ctrl.sv
// Controller state machine of the code table: sequences load, build,
// lookup and decode items. Depends on hct_pkg.
module hct_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  hct_pkg::action_type req_action,
   input  hct_pkg::status_type status,
   output hct_pkg::cmd_type    cmd,
   output logic                req_ready
);

   hct_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hct_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hct_pkg::ST_IDLE: begin
            if (req_valid) begin
               unique case (req_action)
                  hct_pkg::ACT_LOAD:   state_in = hct_pkg::ST_LOAD;
                  hct_pkg::ACT_BUILD:  state_in = hct_pkg::ST_CLEAR;
                  hct_pkg::ACT_LOOKUP: state_in = hct_pkg::ST_LOOKUP_RD;
                  hct_pkg::ACT_DECODE: state_in = hct_pkg::ST_DECODE;
                  default:             state_in = hct_pkg::ST_IDLE;
               endcase
            end
         end
         hct_pkg::ST_LOAD:       state_in = hct_pkg::ST_FINISH;
         hct_pkg::ST_LOOKUP_RD:  state_in = hct_pkg::ST_LOOKUP_RES;
         hct_pkg::ST_LOOKUP_RES: state_in = hct_pkg::ST_FINISH;
         hct_pkg::ST_CLEAR:      state_in = hct_pkg::ST_COUNT;
         hct_pkg::ST_COUNT: begin
            if (status.scan_done) begin
               state_in = hct_pkg::ST_NEXT;
            end
         end
         hct_pkg::ST_NEXT: begin
            if (status.bits_last) begin
               state_in = hct_pkg::ST_ASSIGN;
            end
         end
         hct_pkg::ST_ASSIGN: begin
            if (status.scan_done) begin
               state_in = hct_pkg::ST_FINISH;
            end
         end
         hct_pkg::ST_DECODE: begin
            if (status.match || status.scan_done) begin
               state_in = hct_pkg::ST_FINISH;
            end
         end
         hct_pkg::ST_FINISH: begin
            if (status.rsp_free) begin
               state_in = hct_pkg::ST_IDLE;
            end
         end
         default: state_in = hct_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         hct_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            cmd.scan_start = req_valid && (req_action == hct_pkg::ACT_DECODE);
         end
         hct_pkg::ST_LOAD:       cmd.load_wr    = 1'b1;
         hct_pkg::ST_LOOKUP_RD:  cmd.lookup_rd  = 1'b1;
         hct_pkg::ST_LOOKUP_RES: cmd.lookup_res = 1'b1;
         hct_pkg::ST_CLEAR: begin
            cmd.build_clear = 1'b1;
            cmd.scan_start  = 1'b1;
         end
         hct_pkg::ST_COUNT:      cmd.count_en   = 1'b1;
         hct_pkg::ST_NEXT: begin
            cmd.next_step  = 1'b1;
            // launch the assign walk on the last first-code step
            cmd.scan_start = status.bits_last;
         end
         hct_pkg::ST_ASSIGN:     cmd.assign_en  = 1'b1;
         hct_pkg::ST_DECODE: begin
            cmd.decode_en = 1'b1;
            cmd.scan_stop = status.match;
         end
         hct_pkg::ST_FINISH:     cmd.rsp_load   = status.rsp_free;
         default: ;
      endcase
   end

endmodule

>>> rtl/hct_dp.sv
// Datapath of the code table: length and code RAMs, symbol walk, histogram,
// first-code registers, result and response registers. Depends on hct_pkg, hct_ram.
module hct_dp #(
   parameter int MAX_SYMBOLS = hct_pkg::MAX_SYMBOLS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  hct_pkg::cmd_type               cmd,
   output hct_pkg::status_type            status,
   input  logic [hct_pkg::SYMBOL_W-1:0]   req_symbol,
   input  logic [hct_pkg::LENGTH_W-1:0]   req_length,
   input  logic [hct_pkg::WINDOW_W-1:0]   req_bit_window,
   input  logic                           csr_we,
   input  logic [hct_pkg::COUNT_W-1:0]    csr_wdata,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic                           rsp_found,
   output logic [hct_pkg::SYMBOL_W-1:0]   rsp_result_symbol,
   output logic [hct_pkg::CODE_W-1:0]     rsp_code,
   output logic [hct_pkg::LENGTH_W-1:0]   rsp_code_length
);

   localparam int ADDR_W = $clog2(MAX_SYMBOLS);
   localparam int CNT_W  = ADDR_W + 1;
   localparam int SW     = hct_pkg::SYMBOL_W;
   localparam int LW     = hct_pkg::LENGTH_W;
   localparam int CW     = hct_pkg::CODE_W;
   localparam int HW     = hct_pkg::HIST_W;
   localparam int NW     = hct_pkg::NEXT_W;
   localparam int BINS   = hct_pkg::LEN_BINS;

   // latched request fields and symbol count
   logic [SW-1:0] sym_ff;
   logic [LW-1:0] len_ff;
   logic [CW-1:0] win_ff;
   logic [hct_pkg::COUNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sym_ff <= req_symbol;
         len_ff <= req_length;
         win_ff <= req_bit_window;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= hct_pkg::COUNT_RESET;
      end else if (csr_we) begin
         count_ff <= csr_wdata;
      end
   end

   // active alphabet size, min(symbol_count, MAX_SYMBOLS)
   logic [31:0]      cnt_wide;
   logic [CNT_W-1:0] act_cnt;
   assign cnt_wide = 32'(count_ff);
   assign act_cnt  = (cnt_wide < 32'(MAX_SYMBOLS)) ? CNT_W'(cnt_wide) : CNT_W'(MAX_SYMBOLS);

   logic [ADDR_W+SW-1:0] sym_wide;
   logic [ADDR_W-1:0]    sym_addr;
   logic                 sym_in_range;
   assign sym_wide     = {{ADDR_W{1'b0}}, sym_ff};
   assign sym_addr     = sym_wide[ADDR_W-1:0];
   assign sym_in_range = (32'(sym_ff) < 32'(MAX_SYMBOLS));

   // symbol walk: idx_ff is the address on the RAM read port, rd_* the returned entry
   logic             issuing_ff, issuing_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             rd_valid_ff, rd_valid_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;

   always_comb begin
      issuing_in  = issuing_ff;
      idx_in      = idx_ff;
      rd_valid_in = issuing_ff;
      rd_idx_in   = idx_ff;
      if (cmd.scan_start) begin
         issuing_in = (act_cnt != '0);
         idx_in     = '0;
      end else if (cmd.scan_stop) begin
         issuing_in  = 1'b0;
         rd_valid_in = 1'b0;
      end else if (issuing_ff) begin
         idx_in = CNT_W'(idx_ff + 1'b1);
         if (CNT_W'(idx_ff + 1'b1) == act_cnt) begin
            issuing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issuing_ff  <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else begin
         issuing_ff  <= issuing_in;
         rd_valid_ff <= rd_valid_in;
      end
      idx_ff    <= idx_in;
      rd_idx_ff <= rd_idx_in;
   end

   // symbol tables
   logic [ADDR_W-1:0] rd_addr;
   logic [LW-1:0]     len_rd;
   logic [CW-1:0]     code_rd;
   logic              len_we;
   logic [LW-1:0]     len_wdata;
   logic              code_we;
   logic [CW-1:0]     code_wdata;
   logic              rd_used;

   logic [HW-1:0] hist_ff [BINS];
   logic [HW-1:0] hist_in [BINS];
   logic [NW-1:0] next_ff [BINS];
   logic [NW-1:0] next_in [BINS];
   logic [LW-1:0] bit_ff, bit_in;
   logic [NW-1:0] c_ff, c_in, c_new;

   assign rd_addr   = cmd.lookup_rd ? sym_addr : idx_ff[ADDR_W-1:0];
   assign len_we    = cmd.load_wr && sym_in_range;
   // drop lengths beyond the longest code to unused
   assign len_wdata = (32'(len_ff) <= 32'(hct_pkg::MAX_CODE_BITS)) ? len_ff : '0;
   assign rd_used   = rd_valid_ff && (len_rd != '0);
   assign code_we   = cmd.assign_en && rd_used;
   assign code_wdata = next_ff[len_rd][CW-1:0];

   hct_ram #(
      .WIDTH (LW),
      .DEPTH (MAX_SYMBOLS)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (len_we),
      .wr_addr (sym_addr),
      .wr_data (len_wdata),
      .rd_addr (rd_addr),
      .rd_data (len_rd)
   );

   hct_ram #(
      .WIDTH (CW),
      .DEPTH (MAX_SYMBOLS)
   ) u_code_ram (
      .clock   (clock),
      .wr_en   (code_we),
      .wr_addr (rd_idx_ff[ADDR_W-1:0]),
      .wr_data (code_wdata),
      .rd_addr (rd_addr),
      .rd_data (code_rd)
   );

   // histogram and first codes
   assign c_new = NW'((c_ff + NW'(hist_ff[LW'(bit_ff - 1'b1)])) << 1);

   always_comb begin
      hist_in = hist_ff;
      next_in = next_ff;
      bit_in  = bit_ff;
      c_in    = c_ff;
      if (cmd.build_clear) begin
         for (int i = 0; i < BINS; i++) begin
            hist_in[i] = '0;
            next_in[i] = '0;
         end
         bit_in = LW'(1);
         c_in   = '0;
      end else if (cmd.count_en && rd_used) begin
         hist_in[len_rd] = HW'(hist_ff[len_rd] + 1'b1);
      end else if (cmd.next_step) begin
         next_in[bit_ff] = c_new;
         c_in            = c_new;
         bit_in          = LW'(bit_ff + 1'b1);
      end else if (code_we) begin
         next_in[len_rd] = NW'(next_ff[len_rd] + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      hist_ff <= hist_in;
      next_ff <= next_in;
      bit_ff  <= bit_in;
      c_ff    <= c_in;
   end

   // decode compare: top length bits of the window, MSB first
   logic [CW-1:0]    top;
   logic [CNT_W+SW-1:0] rd_sym_wide;
   assign top         = win_ff >> (LW'(CW) - len_rd);
   assign rd_sym_wide = {{SW{1'b0}}, rd_idx_ff};

   // result registers
   logic          res_found_ff, res_found_in;
   logic [SW-1:0] res_sym_ff, res_sym_in;
   logic [CW-1:0] res_code_ff, res_code_in;
   logic [LW-1:0] res_len_ff, res_len_in;

   always_comb begin
      res_found_in = res_found_ff;
      res_sym_in   = res_sym_ff;
      res_code_in  = res_code_ff;
      res_len_in   = res_len_ff;
      if (cmd.accept) begin
         res_found_in = 1'b0;
         res_sym_in   = '0;
         res_code_in  = '0;
         res_len_in   = '0;
      end else if (cmd.lookup_res) begin
         res_sym_in = sym_ff;
         if (sym_in_range && (len_rd != '0)) begin
            res_found_in = 1'b1;
            res_code_in  = code_rd;
            res_len_in   = len_rd;
         end
      end else if (cmd.decode_en && status.match) begin
         res_found_in = 1'b1;
         res_sym_in   = rd_sym_wide[SW-1:0];
         res_code_in  = top;
         res_len_in   = len_rd;
      end
   end

   always_ff @(posedge clock) begin
      res_found_ff <= res_found_in;
      res_sym_ff   <= res_sym_in;
      res_code_ff  <= res_code_in;
      res_len_ff   <= res_len_in;
   end

   // response register
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_found_ff;
   logic [SW-1:0] rsp_sym_ff;
   logic [CW-1:0] rsp_code_ff;
   logic [LW-1:0] rsp_len_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.rsp_load) begin
         rsp_found_ff <= res_found_ff;
         rsp_sym_ff   <= res_sym_ff;
         rsp_code_ff  <= res_code_ff;
         rsp_len_ff   <= res_len_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_result_symbol = rsp_sym_ff;
   assign rsp_code          = rsp_code_ff;
   assign rsp_code_length   = rsp_len_ff;

   assign status.scan_done = !issuing_ff && !rd_valid_ff;
   assign status.bits_last = (bit_ff == LW'(hct_pkg::MAX_CODE_BITS));
   assign status.match     = rd_used && (top == code_rd);
   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;

endmodule
